[rtl/ipv4_longest_prefix_router_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the longest-prefix router
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef IPV4_LONGEST_PREFIX_ROUTER_ASSERT_SVH
`define IPV4_LONGEST_PREFIX_ROUTER_ASSERT_SVH

// Check a property on every edge out of reset
`define LPR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition is followed by a result in the next cycle
`define LPR_ASSERT_NEXT(name, pre, post, msg) \
  `LPR_ASSERT(name, (pre) |=> (post), msg)

`endif

[rtl/lpr_pkg.sv]
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared widths, codes and types of the longest-prefix router.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned LenW    = 6;
  localparam int unsigned IfW     = 4;
  localparam int unsigned TtlW    = 8;
  localparam int unsigned StatusW = 3;
  // Number of codes the interface field can carry
  localparam int unsigned IfCodes = 16;

  localparam logic [LenW-1:0] MaxLen = LenW'(AddrW);
  localparam logic [TtlW-1:0] TtlMin = TtlW'(1);

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_ROUTE = 1'b1
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_ADDED        = 3'd0,
    ST_FORWARDED    = 3'd1,
    ST_DROP_TTL     = 3'd2,
    ST_DROP_NOROUTE = 3'd3,
    ST_TABLE_FULL   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [AddrW-1:0] prefix;
    logic [LenW-1:0]  len;
    logic             has_gw;
    logic [AddrW-1:0] gw;
    logic [IfW-1:0]   intf;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic             found;
    logic             has_gw;
    logic [AddrW-1:0] gw;
    logic [IfW-1:0]   intf;
  } best_t;

  // High-order mask of len bits, len at most the address width
  function automatic logic [AddrW-1:0] prefix_mask(input logic [LenW-1:0] len);
    logic [AddrW-1:0] m;
    if (len == '0) begin
      m = '0;
    end else begin
      m = {AddrW{1'b1}} << (MaxLen - len);
    end
    return m;
  endfunction

endpackage

[rtl/lpr_if.sv]
// ----------------------------------------------------------------------------
// lpr_if
// Valid/ready channels of the longest-prefix router: request and response.
// ----------------------------------------------------------------------------
interface lpr_req_if;
  import lpr_pkg::*;

  logic             valid;
  logic             ready;
  logic             opcode;
  logic [AddrW-1:0] add_prefix;
  logic [LenW-1:0]  add_len;
  logic             has_gateway;
  logic [AddrW-1:0] gateway_addr;
  logic [IfW-1:0]   route_interface;
  logic [AddrW-1:0] dst_addr;
  logic [TtlW-1:0]  ttl_in;

  modport source (
    output valid, opcode, add_prefix, add_len, has_gateway,
           gateway_addr, route_interface, dst_addr, ttl_in,
    input  ready
  );

  modport sink (
    input  valid, opcode, add_prefix, add_len, has_gateway,
           gateway_addr, route_interface, dst_addr, ttl_in,
    output ready
  );
endinterface

interface lpr_rsp_if;
  import lpr_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [IfW-1:0]     out_interface;
  logic [AddrW-1:0]   next_hop_addr;
  logic [TtlW-1:0]    ttl_out;

  modport source (
    output valid, status, out_interface, next_hop_addr, ttl_out,
    input  ready
  );

  modport sink (
    input  valid, status, out_interface, next_hop_addr, ttl_out,
    output ready
  );
endinterface

[rtl/lpr_scan.sv]
// ----------------------------------------------------------------------------
// lpr_scan
// Compares one entry a cycle while stepped against the destination and keeps
// the longest match seen so far; the earliest entry wins among equal lengths.
// ----------------------------------------------------------------------------
module lpr_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lpr_pkg::scan_ctl_t ctl_i,
  input  logic [31:0]        dst_i,
  input  lpr_pkg::entry_t    entry_i,
  output lpr_pkg::best_t     best_o
);
  import lpr_pkg::*;

  logic             found_q;
  logic [LenW-1:0]  len_q;
  logic             has_gw_q;
  logic [AddrW-1:0] gw_q;
  logic [IfW-1:0]   intf_q;

  logic [AddrW-1:0] mask;
  logic             hit;
  logic             better;

  // Match the masked prefix, take it only if strictly longer
  always_comb begin
    mask   = prefix_mask(entry_i.len);
    hit    = ((dst_i ^ entry_i.prefix) & mask) == '0;
    better = hit && (!found_q || (entry_i.len > len_q));
  end

  // Track whether any entry matched
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
    end else if (ctl_i.step && better) begin
      found_q <= 1'b1;
    end
  end

  // Hold the best entry's route data
  always_ff @(posedge clk_i) begin
    if (ctl_i.step && better) begin
      len_q    <= entry_i.len;
      has_gw_q <= entry_i.has_gw;
      gw_q     <= entry_i.gw;
      intf_q   <= entry_i.intf;
    end
  end

  assign best_o = '{found: found_q, has_gw: has_gw_q, gw: gw_q, intf: intf_q};

endmodule

[rtl/ipv4_longest_prefix_router.sv]
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_router
// Adds, TTL drops and empty-table lookups go from idle straight to done;
// other lookups first scan the N stored entries, then go to done. The result
// is registered into the output once that is free. A new request is taken
// only in idle, after the last result is loaded; scans read one entry a cycle.
// Reset clears the entry count and control; route memory is not cleared.
// ----------------------------------------------------------------------------
`include "ipv4_longest_prefix_router_assert.svh"

module ipv4_longest_prefix_router #(
  parameter int unsigned TABLE_DEPTH    = 64,
  parameter int unsigned NUM_INTERFACES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lpr_req_if.sink   req_i,
  lpr_rsp_if.source rsp_o
);
  import lpr_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(TABLE_DEPTH);

  state_e state_q, state_d;

  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] cmp_ptr_q;
  logic [IdxW-1:0] rd_addr;

  entry_t rt_mem [TABLE_DEPTH];
  entry_t rd_q;
  entry_t new_entry;

  logic [IfW-1:0] if_red [IfCodes];

  logic             req_acc;
  logic             mem_we;
  logic             from_scan_d;
  logic             from_scan_q;
  status_e          pend_status_d, pend_status_q;
  logic [AddrW-1:0] dst_q;
  logic [TtlW-1:0]  ttl_q;
  logic             last;
  logic             load_out;
  scan_ctl_t        scan_ctl;
  best_t            best;

  status_e          res_status;
  logic [IfW-1:0]   res_intf;
  logic [AddrW-1:0] res_nh;
  logic [TtlW-1:0]  res_ttl;

  logic             out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [IfW-1:0]   out_intf_q;
  logic [AddrW-1:0] out_nh_q;
  logic [TtlW-1:0]  out_ttl_q;

  // Reduce interface codes to the configured interface count
  for (genvar g = 0; g < IfCodes; g++) begin : g_if_red
    assign if_red[g] = IfW'(g % NUM_INTERFACES);
  end

  assign req_acc = req_i.valid && req_i.ready;
  assign last    = cmp_ptr_q == IdxW'(count_q - CntW'(1));

  // Decode the word: add write, scan need, and the status when no scan runs
  always_comb begin
    mem_we        = 1'b0;
    from_scan_d   = 1'b0;
    pend_status_d = ST_DROP_NOROUTE;
    if (req_i.opcode == OP_ADD) begin
      if (count_q >= DepthCnt) begin
        pend_status_d = ST_TABLE_FULL;
      end else begin
        pend_status_d = ST_ADDED;
        mem_we        = req_acc;
      end
    end else if (req_i.ttl_in <= TtlMin) begin
      pend_status_d = ST_DROP_TTL;
    end else begin
      from_scan_d = count_q != '0;
    end
  end

  // Build the stored entry: saturate length, reduce interface
  always_comb begin
    new_entry.prefix = req_i.add_prefix;
    new_entry.len    = (req_i.add_len > MaxLen) ? MaxLen : req_i.add_len;
    new_entry.has_gw = req_i.has_gateway;
    new_entry.gw     = req_i.gateway_addr;
    new_entry.intf   = if_red[req_i.route_interface];
  end

  // Next state, handshake and scan control
  always_comb begin
    state_d        = state_q;
    req_i.ready    = 1'b0;
    load_out       = 1'b0;
    rd_addr        = IdxW'(cmp_ptr_q + IdxW'(1));
    scan_ctl.clear = 1'b0;
    scan_ctl.step  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        rd_addr     = '0;
        if (req_acc) begin
          scan_ctl.clear = 1'b1;
          state_d        = from_scan_d ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        scan_ctl.step = 1'b1;
        if (last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance the entry count and the compare pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      cmp_ptr_q <= '0;
    end else begin
      if (mem_we) begin
        count_q <= count_q + CntW'(1);
      end
      if (req_acc) begin
        cmp_ptr_q <= '0;
      end else if (scan_ctl.step) begin
        cmp_ptr_q <= IdxW'(cmp_ptr_q + IdxW'(1));
      end
    end
  end

  // Route memory: append at the count, one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rt_mem[count_q[IdxW-1:0]] <= new_entry;
    end
    rd_q <= rt_mem[rd_addr];
  end

  // Hold the request fields the result needs
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      dst_q         <= req_i.dst_addr;
      ttl_q         <= req_i.ttl_in;
      from_scan_q   <= from_scan_d;
      pend_status_q <= pend_status_d;
    end
  end

  lpr_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .dst_i   (dst_q),
    .entry_i (rd_q),
    .best_o  (best)
  );

  // Form the result word
  always_comb begin
    res_status = from_scan_q ? ST_DROP_NOROUTE : pend_status_q;
    res_intf   = '0;
    res_nh     = '0;
    res_ttl    = '0;
    if (from_scan_q && best.found) begin
      res_status = ST_FORWARDED;
      res_intf   = best.intf;
      res_nh     = best.has_gw ? best.gw : dst_q;
      res_ttl    = ttl_q - TtlW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= res_status;
      out_intf_q   <= res_intf;
      out_nh_q     <= res_nh;
      out_ttl_q    <= res_ttl;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.out_interface = out_intf_q;
  assign rsp_o.next_hop_addr = out_nh_q;
  assign rsp_o.ttl_out       = out_ttl_q;

  // Checks
  `LPR_ASSERT(a_count_bound, count_q <= DepthCnt, "entry count beyond table depth")
  `LPR_ASSERT_NEXT(a_add_grows, mem_we, count_q == $past(count_q) + CntW'(1), "add did not grow table")
  `LPR_ASSERT_NEXT(a_scan_start, req_acc && from_scan_d, state_q == S_SCAN, "lookup did not start scan")
  `LPR_ASSERT(a_fwd_ttl, rsp_o.valid && rsp_o.status == ST_FORWARDED |-> rsp_o.ttl_out != '0, "forwarded with zero ttl")

endmodule
